[rtl/core/irf_pkg.sv]
`timescale 1ns / 1ps
package irf_pkg;

  localparam int unsigned DEFAULT_ROUTE_ENTRIES = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PLEN_W = 6;
  localparam int unsigned TTL_W  = 8;
  localparam int unsigned CSUM_W = 16;
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned WCNT_W = 3;
  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;

  localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

  // command codes
  localparam logic CMD_ADD_ROUTE = 1'b0;
  localparam logic CMD_HDR_WORD  = 1'b1;

  // header word positions
  localparam logic [WCNT_W-1:0] WORD_TTL  = 3'd2;
  localparam logic [WCNT_W-1:0] WORD_LAST = 3'd4;

  // register byte addresses
  localparam logic [APB_AW-1:0] REG_LOCAL_ADDR = 2'd0;

  typedef enum logic [1:0] {
    VERDICT_FORWARD  = 2'd0,
    VERDICT_LOCAL    = 2'd1,
    VERDICT_DROP_TTL = 2'd2,
    VERDICT_NO_ROUTE = 2'd3
  } verdict_e;

  // lookup token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] hop;
  } link_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len > MAX_PLEN) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

[rtl/core/irf_cell.sv]
`timescale 1ns / 1ps
module irf_cell #(
  parameter int unsigned ROUTE_ENTRIES = irf_pkg::DEFAULT_ROUTE_ENTRIES,
  parameter int unsigned CELL_INDEX    = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(ROUTE_ENTRIES+1)-1:0]    count_i,
  input  logic                                  wr_en_i,
  input  logic [irf_pkg::ADDR_W-1:0]            wr_dest_i,
  input  logic [irf_pkg::ADDR_W-1:0]            wr_mask_i,
  input  logic [irf_pkg::ADDR_W-1:0]            wr_hop_i,
  input  irf_pkg::link_t                        link_i,
  output irf_pkg::link_t                        link_o
);
  import irf_pkg::*;

  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CW-1:0] MY_INDEX = CW'(CELL_INDEX);

  logic [ADDR_W-1:0] dest_q, mask_q, hop_q;
  link_t             link_q, link_d;
  logic              occupied, match;

  // entries fill in order, so the count tells which cells hold a route
  assign occupied = MY_INDEX < count_i;
  assign match    = occupied && ((link_i.addr & mask_q) == dest_q);

  always_comb begin
    link_d = link_i;
    if (!link_i.found && match) begin
      link_d.found = 1'b1;
      link_d.hop   = hop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && count_i == MY_INDEX) begin
      dest_q <= wr_dest_i & wr_mask_i;
      mask_q <= wr_mask_i;
      hop_q  <= wr_hop_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

[rtl/core/ipv4_route_forward.sv]
`timescale 1ns / 1ps
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------
// command   | in        | start / busy           | command, route_*, header_word
// result    | out       | result_valid_o strobe  | verdict, next_hop, new_ttl, new_checksum
// config    | in        | apb psel/penable/pready| local_address at byte address 0
//
// an add-route item and the first four header words are accepted whenever busy is low
// the fifth header word starts the lookup: the lookup token walks
// the row of route cells one cell a cycle, then the result is registered
// busy is high during the walk
// asynchronous active-low reset empties the table and clears the packet state
// the result is a one-cycle strobe, there is no back pressure on the output
module ipv4_route_forward #(
  parameter int unsigned ROUTE_ENTRIES = irf_pkg::DEFAULT_ROUTE_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [irf_pkg::ADDR_W-1:0]   route_dest_i,
  input  logic [irf_pkg::PLEN_W-1:0]   route_prefix_len_i,
  input  logic [irf_pkg::ADDR_W-1:0]   route_next_hop_i,
  input  logic [irf_pkg::ADDR_W-1:0]   header_word_i,
  output logic                         result_valid_o,
  output logic [1:0]                   verdict_o,
  output logic [irf_pkg::ADDR_W-1:0]   next_hop_o,
  output logic [irf_pkg::TTL_W-1:0]    new_ttl_o,
  output logic [irf_pkg::CSUM_W-1:0]   new_checksum_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irf_pkg::APB_AW-1:0]   paddr,
  input  logic [irf_pkg::APB_DW-1:0]   pwdata,
  output logic [irf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import irf_pkg::*;

  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ROUTE_ENTRIES);

  logic [ADDR_W-1:0] local_addr_q;
  logic [CW-1:0]     count_q;
  logic [WCNT_W-1:0] word_cnt_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TTL_W-1:0]  ttl_q;
  logic              busy_q;
  logic [SUM_W-1:0]  fin_sum_q;
  logic [TTL_W-1:0]  fin_ttl_q;
  logic              ttl_zero_q, local_q;

  logic              res_valid_q;
  verdict_e          res_verdict_q;
  logic [ADDR_W-1:0] res_hop_q;
  logic [TTL_W-1:0]  res_ttl_q;
  logic [CSUM_W-1:0] res_ck_q;

  logic              accept, add_route, hdr_word, last_word, wr_en;
  logic [ADDR_W-1:0] wr_mask;
  logic [15:0]       hi, lo;
  logic [TTL_W-1:0]  ttl_word, ttl_dec;
  logic [16:0]       addend;
  logic [16:0]       fold1;
  logic [CSUM_W-1:0] fold2;
  link_t             link [ROUTE_ENTRIES+1];
  link_t             tail;

  assign accept    = start && !busy_q;
  assign add_route = accept && command_i == CMD_ADD_ROUTE;
  assign hdr_word  = accept && command_i == CMD_HDR_WORD;
  assign last_word = hdr_word && word_cnt_q == WORD_LAST;
  assign wr_en     = add_route && count_q < FULL_COUNT;
  assign wr_mask   = prefix_mask(route_prefix_len_i);

  assign hi       = header_word_i[31:16];
  assign lo       = header_word_i[15:0];
  assign ttl_word = hi[15:8];
  assign ttl_dec  = ttl_word - 8'd1;

  // third word: ttl replaced by ttl-1, incoming checksum taken as zero
  always_comb begin
    if (word_cnt_q == WORD_TTL) begin
      addend = {1'b0, ttl_dec, hi[7:0]};
    end else begin
      addend = {1'b0, hi} + {1'b0, lo};
    end
    sum_d = sum_q + SUM_W'(addend);
  end

  always_comb begin
    link[0]       = '0;
    link[0].valid = last_word;
    link[0].addr  = header_word_i;
  end

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    irf_cell #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES),
      .CELL_INDEX   (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .count_i  (count_q),
      .wr_en_i  (wr_en),
      .wr_dest_i(route_dest_i),
      .wr_mask_i(wr_mask),
      .wr_hop_i (route_next_hop_i),
      .link_i   (link[g]),
      .link_o   (link[g+1])
    );
  end

  assign tail = link[ROUTE_ENTRIES];

  // end-around carry fold of the accumulated sum
  assign fold1 = {1'b0, fin_sum_q[15:0]} + 17'(fin_sum_q[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      count_q      <= '0;
      word_cnt_q   <= '0;
      sum_q        <= '0;
      ttl_q        <= '0;
      busy_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_LOCAL_ADDR) begin
        local_addr_q <= pwdata;
      end
      if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
      if (hdr_word) begin
        if (last_word) begin
          word_cnt_q <= '0;
          sum_q      <= '0;
          ttl_q      <= '0;
          busy_q     <= 1'b1;
        end else begin
          word_cnt_q <= word_cnt_q + WCNT_W'(1);
          sum_q      <= sum_d;
          if (word_cnt_q == WORD_TTL) begin
            ttl_q <= ttl_word;
          end
        end
      end
      if (tail.valid) begin
        busy_q <= 1'b0;
      end
      res_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_word) begin
      fin_sum_q  <= sum_d;
      fin_ttl_q  <= ttl_q;
      ttl_zero_q <= ttl_q == '0;
      local_q    <= header_word_i == local_addr_q;
    end
    if (tail.valid) begin
      if (ttl_zero_q) begin
        res_verdict_q <= VERDICT_DROP_TTL;
        res_hop_q     <= '0;
        res_ttl_q     <= '0;
        res_ck_q      <= '0;
      end else if (local_q) begin
        res_verdict_q <= VERDICT_LOCAL;
        res_hop_q     <= '0;
        res_ttl_q     <= '0;
        res_ck_q      <= '0;
      end else if (tail.found) begin
        res_verdict_q <= VERDICT_FORWARD;
        res_hop_q     <= tail.hop;
        res_ttl_q     <= fin_ttl_q - 8'd1;
        res_ck_q      <= ~fold2;
      end else begin
        res_verdict_q <= VERDICT_NO_ROUTE;
        res_hop_q     <= '0;
        res_ttl_q     <= '0;
        res_ck_q      <= '0;
      end
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign verdict_o      = res_verdict_q;
  assign next_hop_o     = res_hop_q;
  assign new_ttl_o      = res_ttl_q;
  assign new_checksum_o = res_ck_q;
  assign prdata         = (paddr == REG_LOCAL_ADDR) ? local_addr_q : '0;
  assign pready         = 1'b1;

endmodule
